[sv/ash_pkg.sv]
// ----------------------------------------------------------------------------
// ash_pkg
// Shared constants, types and mixing functions for the address scramble hash.
// ----------------------------------------------------------------------------
package ash_pkg;

  localparam int unsigned HashW          = 32;
  localparam int unsigned ExtraRounds    = 256;
  localparam int unsigned RoundsPerStage = 4;
  localparam int unsigned ExtraStages    = (ExtraRounds + RoundsPerStage - 1) / RoundsPerStage;
  // two stages for the four address bytes, then the data-free rounds
  localparam int unsigned NumPipe        = 2 + ExtraStages;

  typedef logic [HashW-1:0] hash_t;

  function automatic hash_t mix_round(input hash_t h);
    hash_t t;
    t = h + (h << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic hash_t byte_round(input hash_t h, input logic [7:0] b);
    hash_t t;
    t = h + {{(HashW-8){1'b0}}, b};
    return mix_round(t);
  endfunction

  // rounds of one pipeline stage; rounds past the end pass through
  function automatic hash_t extra_group(input hash_t h, input int unsigned grp);
    hash_t t;
    t = h;
    for (int unsigned j = 0; j < RoundsPerStage; j++) begin
      if (grp * RoundsPerStage + j < ExtraRounds) begin
        t = mix_round(t);
      end
    end
    return t;
  endfunction

  function automatic hash_t avalanche(input hash_t h);
    hash_t t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

[sv/ash_out_buf.sv]
// ----------------------------------------------------------------------------
// ash_out_buf
// Output register with a skid entry; full flag holds the hash pipeline.
// ----------------------------------------------------------------------------
module ash_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ash_pkg::hash_t push_data_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output ash_pkg::hash_t out_data_o,
  output logic           full_o
);

  logic           out_v_q, out_v_d;
  logic           sk_v_q, sk_v_d;
  ash_pkg::hash_t out_d_q, out_d_d;
  ash_pkg::hash_t sk_d_q, sk_d_d;
  logic           pop;

  assign pop = out_v_q && !out_stall_i;

  always_comb begin
    out_v_d = out_v_q;
    out_d_d = out_d_q;
    sk_v_d  = sk_v_q;
    sk_d_d  = sk_d_q;
    if (!out_v_q || pop) begin
      if (sk_v_q) begin
        out_v_d = 1'b1;
        out_d_d = sk_d_q;
        sk_v_d  = push_i;
        sk_d_d  = push_data_i;
      end else begin
        out_v_d = push_i;
        out_d_d = push_data_i;
      end
    end else if (push_i) begin
      sk_v_d = 1'b1;
      sk_d_d = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_d_q <= out_d_d;
    sk_d_q  <= sk_d_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_d_q;
  assign full_o      = sk_v_q;

endmodule

[sv/address_scramble_hash_top.sv]
// ----------------------------------------------------------------------------
// address_scramble_hash_top
// Path: ash_pkg::NumPipe hash stages, then the output register (256 extra rounds, 4 per stage).
// Throughput: one item per cycle while in_stall_o is low; each extra-round stage holds four mixing rounds.
// An output register plus a skid entry let a new item in while a result waits.
// Reset clears all valid bits; the hash data registers are not reset.
// ----------------------------------------------------------------------------
module address_scramble_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  logic [ash_pkg::NumPipe-1:0] vld_q;
  ash_pkg::hash_t              h_q [ash_pkg::NumPipe];
  logic [15:0]                 hi_q;
  logic                        en;
  logic                        full;
  ash_pkg::hash_t              h0_d;
  ash_pkg::hash_t              h1_d;

  assign en         = !full;
  assign in_stall_o = full;

  always_comb begin
    h0_d = ash_pkg::byte_round(ash_pkg::hash_t'(0), address_i[7:0]);
    h0_d = ash_pkg::byte_round(h0_d, address_i[15:8]);
    h1_d = ash_pkg::byte_round(h_q[0], hi_q[7:0]);
    h1_d = ash_pkg::byte_round(h1_d, hi_q[15:8]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[ash_pkg::NumPipe-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q[0] <= h0_d;
      hi_q   <= address_i[31:16];
      h_q[1] <= h1_d;
      for (int unsigned k = 2; k < ash_pkg::NumPipe; k++) begin
        h_q[k] <= ash_pkg::extra_group(h_q[k-1], k - 2);
      end
    end
  end

  ash_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (en && vld_q[ash_pkg::NumPipe-1]),
    .push_data_i (ash_pkg::avalanche(h_q[ash_pkg::NumPipe-1])),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (hash_value_o),
    .full_o      (full)
  );

endmodule
